>>> design/scc_pkg.sv
package scc_pkg;

  // Field widths of the two channels.
  localparam int OPC_W    = 2;
  localparam int SECS_W   = 32;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int WDAY_W   = 3;

  // Operation codes; the spare code behaves as a read.
  localparam logic [OPC_W-1:0] OPC_TICK = 2'd0;
  localparam logic [OPC_W-1:0] OPC_SET  = 2'd1;
  localparam logic [OPC_W-1:0] OPC_READ = 2'd2;

  // Calendar constants.
  localparam logic [YEAR_W-1:0] EPOCH_YEAR_C       = 12'd1970;
  localparam logic [YEAR_W-1:0] NO_LEAP_CENTURY_C  = 12'd2100;
  localparam logic [8:0]        YEAR_LEN_C         = 9'd365;
  localparam logic [8:0]        LEAP_YEAR_LEN_C    = 9'd366;
  localparam logic [16:0]       SECS_PER_DAY_C     = 17'd86400;
  localparam logic [16:0]       SECS_PER_HOUR_C    = 17'd3600;
  localparam logic [16:0]       SECS_PER_MIN_C     = 17'd60;
  localparam logic [16:0]       DAYS_PER_WEEK_C    = 17'd7;
  localparam logic [2:0]        EPOCH_WEEKDAY_C    = 3'd4;
  localparam logic [MONTH_W-1:0] LAST_MONTH_IDX_C  = 4'd11;

  // Reciprocals for the divisions by constants. The dividend is first shifted
  // right by the power of two in the divisor; the quotient is the top of the
  // product. Each is rounded up and exact over the dividends that occur.
  localparam logic [25:0] DAY_RECIP_C  = 26'd50903317;  // 2^35 / 675
  localparam logic [13:0] HOUR_RECIP_C = 14'd9321;      // 2^21 / 225
  localparam logic [10:0] MIN_RECIP_C  = 11'd1093;      // 2^14 / 15
  localparam logic [16:0] WEEK_RECIP_C = 17'd74899;     // 2^19 / 7

  // Write side of the queue.
  typedef struct packed {
    logic              valid;
    logic [SECS_W-1:0] secs;
  } push_t;

  // Status of the queue.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Leap rule over the years the counter can reach (1970 to 2106): the only
  // centuries in range are 2000, a leap year, and 2100, which is not.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (y != NO_LEAP_CENTURY_C);
  endfunction

  // Days in a month, month index counted from zero.
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> design/scc_if.sv
interface scc_in_if;
  import scc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPC_W-1:0]    opcode;
  logic [SECS_W-1:0]   new_time;

  modport source (output valid, output opcode, output new_time, input ready);
  modport sink   (input valid, input opcode, input new_time, output ready);
endinterface

interface scc_out_if;
  import scc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SECS_W-1:0]   seconds_now;
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day_of_month;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second;
  logic [WDAY_W-1:0]   weekday;

  modport source (output valid, output seconds_now, output year, output month,
                  output day_of_month, output hour, output minute, output second,
                  output weekday, input ready);
  modport sink   (input valid, input seconds_now, input year, input month,
                  input day_of_month, input hour, input minute, input second,
                  input weekday, output ready);
endinterface

>>> design/scc_front.sv
module scc_front (
  input  logic                clk,
  input  logic                rst_n,
  scc_in_if.sink              in_ch,
  input  scc_pkg::fifo_stat_t stat,
  output scc_pkg::push_t      push
);
  import scc_pkg::*;

  logic [SECS_W-1:0] count_r;
  logic [SECS_W-1:0] count_nxt;
  logic              accept;

  // An item is taken whenever the queue has room.
  assign in_ch.ready = !stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Apply the operation to the counter; the result goes to the queue.
  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      case (in_ch.opcode)
        OPC_TICK: count_nxt = count_r + 32'd1;
        OPC_SET:  count_nxt = in_ch.new_time;
        default:  count_nxt = count_r;
      endcase
    end
  end

  assign push.valid = accept;
  assign push.secs  = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

>>> design/scc_queue.sv
module scc_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  scc_pkg::push_t              push,
  input  logic                        pop,
  output scc_pkg::fifo_stat_t         stat,
  output logic [scc_pkg::SECS_W-1:0]  rd_data
);
  import scc_pkg::*;

  logic [SECS_W-1:0] mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  // Two-entry queue of counter values.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.secs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> design/scc_back.sv
module scc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  scc_pkg::fifo_stat_t         stat,
  input  logic [scc_pkg::SECS_W-1:0]  rd_data,
  output logic                        pop,
  scc_out_if.source                   out_ch
);
  import scc_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_DDAY  = 10'b00_0000_0010,
    ST_RDAY  = 10'b00_0000_0100,
    ST_DHOUR = 10'b00_0000_1000,
    ST_RHOUR = 10'b00_0001_0000,
    ST_DMIN  = 10'b00_0010_0000,
    ST_RMIN  = 10'b00_0100_0000,
    ST_YEAR  = 10'b00_1000_0000,
    ST_MONTH = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SECS_W-1:0]   secs_r, secs_nxt;
  logic [15:0]         days_r, days_nxt;
  logic [16:0]         daysec_r, daysec_nxt;
  logic [11:0]         hrem_r, hrem_nxt;
  logic [12:0]         wq_r, wq_nxt;
  logic [HOUR_W-1:0]   hour_r, hour_nxt;
  logic [MINUTE_W-1:0] min_r, min_nxt;
  logic [SECOND_W-1:0] sec_r, sec_nxt;
  logic [WDAY_W-1:0]   wday_r, wday_nxt;
  logic [YEAR_W-1:0]   year_r, year_nxt;
  logic [MONTH_W-1:0]  mon_r, mon_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                load_out;

  logic [50:0]         day_prod;
  logic [SECS_W-1:0]   day_base;
  logic [SECS_W-1:0]   day_diff;
  logic [16:0]         days_wk;
  logic [31:0]         wk_prod;
  logic [16:0]         wk_base;
  logic [16:0]         wk_diff;
  logic [25:0]         hr_prod;
  logic [16:0]         hr_base;
  logic [16:0]         hr_diff;
  logic [19:0]         mn_prod;
  logic [16:0]         mn_base;
  logic [16:0]         mn_diff;
  logic                leap;
  logic [8:0]          ylen;
  logic [DAY_W-1:0]    mlen;

  // Day number and seconds into the day: 86400 is 128 times 675.
  assign day_prod = {26'd0, secs_r[SECS_W-1:7]} * {25'd0, DAY_RECIP_C};
  assign day_base = {16'd0, days_r} * {15'd0, SECS_PER_DAY_C};
  assign day_diff = secs_r - day_base;

  // Weekday from the day number, counted from a Thursday.
  assign days_wk = {1'b0, days_r} + {14'd0, EPOCH_WEEKDAY_C};
  assign wk_prod = {15'd0, days_wk} * {15'd0, WEEK_RECIP_C};
  assign wk_base = {4'd0, wq_r} * DAYS_PER_WEEK_C;
  assign wk_diff = days_wk - wk_base;

  // Hour and seconds into the hour: 3600 is 16 times 225.
  assign hr_prod = {13'd0, daysec_r[16:4]} * {12'd0, HOUR_RECIP_C};
  assign hr_base = {12'd0, hour_r} * SECS_PER_HOUR_C;
  assign hr_diff = daysec_r - hr_base;

  // Minute and second: 60 is 4 times 15.
  assign mn_prod = {10'd0, hrem_r[11:2]} * {9'd0, MIN_RECIP_C};
  assign mn_base = {11'd0, min_r} * SECS_PER_MIN_C;
  assign mn_diff = {5'd0, hrem_r} - mn_base;

  // Year and month walk helpers.
  assign leap = is_leap(year_r);
  assign ylen = leap ? LEAP_YEAR_LEN_C : YEAR_LEN_C;
  assign mlen = month_len(leap, mon_r);

  assign pop = (state_r == ST_IDLE) && !stat.empty;

  // Sequencer: each quotient followed by its remainder, then the walks.
  always_comb begin
    state_nxt  = state_r;
    secs_nxt   = secs_r;
    days_nxt   = days_r;
    daysec_nxt = daysec_r;
    hrem_nxt   = hrem_r;
    wq_nxt     = wq_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    sec_nxt    = sec_r;
    wday_nxt   = wday_r;
    year_nxt   = year_r;
    mon_nxt    = mon_r;
    load_out   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!stat.empty) begin
          secs_nxt  = rd_data;
          state_nxt = ST_DDAY;
        end
      end
      ST_DDAY: begin
        days_nxt  = day_prod[50:35];
        state_nxt = ST_RDAY;
      end
      ST_RDAY: begin
        daysec_nxt = day_diff[16:0];
        wq_nxt     = wk_prod[31:19];
        state_nxt  = ST_DHOUR;
      end
      ST_DHOUR: begin
        hour_nxt  = hr_prod[25:21];
        wday_nxt  = wk_diff[WDAY_W-1:0];
        state_nxt = ST_RHOUR;
      end
      ST_RHOUR: begin
        hrem_nxt  = hr_diff[11:0];
        state_nxt = ST_DMIN;
      end
      ST_DMIN: begin
        min_nxt   = mn_prod[19:14];
        state_nxt = ST_RMIN;
      end
      ST_RMIN: begin
        sec_nxt   = mn_diff[SECOND_W-1:0];
        year_nxt  = EPOCH_YEAR_C;
        state_nxt = ST_YEAR;
      end
      ST_YEAR: begin
        // One year per cycle until the day count falls inside the year.
        if (days_r < {7'd0, ylen}) begin
          mon_nxt   = '0;
          state_nxt = ST_MONTH;
        end else begin
          days_nxt = days_r - {7'd0, ylen};
          year_nxt = year_r + 12'd1;
        end
      end
      ST_MONTH: begin
        if ((mon_r < LAST_MONTH_IDX_C) && (days_r >= {11'd0, mlen})) begin
          days_nxt = days_r - {11'd0, mlen};
          mon_nxt  = mon_r + 4'd1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the conversion.
  always_ff @(posedge clk) begin
    secs_r   <= secs_nxt;
    days_r   <= days_nxt;
    daysec_r <= daysec_nxt;
    hrem_r   <= hrem_nxt;
    wq_r     <= wq_nxt;
    hour_r   <= hour_nxt;
    min_r    <= min_nxt;
    sec_r    <= sec_nxt;
    wday_r   <= wday_nxt;
    year_r   <= year_nxt;
    mon_r    <= mon_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.seconds_now  <= secs_r;
      out_ch.year         <= year_r;
      out_ch.month        <= mon_r + 4'd1;
      out_ch.day_of_month <= days_r[DAY_W-1:0] + 5'd1;
      out_ch.hour         <= hour_r;
      out_ch.minute       <= min_r;
      out_ch.second       <= sec_r;
      out_ch.weekday      <= wday_r;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

>>> design/seconds_counter_calendar_unit.sv
// Channel   Direction  Carries
// in_ch     sink       opcode, new_time
// out_ch    source     seconds_now, year, month, day_of_month, hour, minute,
//                      second, weekday
//
// The counter is updated in the cycle an item is accepted; its new value
// waits in a two-entry queue for the converter.
// Conversion takes the value, runs six steps of division by constants
// through reciprocal multiplication, walks the years since 1970 one by one,
// then the months, and loads the output.
// Reset (rst_n low, synchronous) clears the counter to zero and empties the
// queue and the output register.
// The input stalls only when the queue is full; a stalled output holds the
// converter once it has finished the next value.

module seconds_counter_calendar_unit (
  input  logic       clk,
  input  logic       rst_n,
  scc_in_if.sink     in_ch,
  scc_out_if.source  out_ch
);
  import scc_pkg::*;

  push_t             push;
  fifo_stat_t        stat;
  logic              pop;
  logic [SECS_W-1:0] rd_data;

  scc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .stat  (stat),
    .push  (push)
  );

  scc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (pop),
    .stat    (stat),
    .rd_data (rd_data)
  );

  scc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .stat    (stat),
    .rd_data (rd_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
